// File: hdl/sravg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor running average alert package
// Shared widths, table size, status codes and register indexes.
// ----------------------------------------------------------------------------
package sravg_pkg;

   // Number of per-sensor table entries; sensor 0 is never valid.
   localparam int NUM_SENSORS = 16;
   localparam int SENSOR_W    = $clog2(NUM_SENSORS);

   localparam int ID_W    = 8;
   localparam int TEMP_W  = 16;
   localparam int TIME_W  = 32;
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 16;
   localparam int CFG_W   = 16;

   localparam int CSR_INDEX_W = 3;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_RESET_GAP = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_READ  = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COOLDOWN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_COLD_LIM  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOT_LIM   = 3'd4;

   // Register values after reset.
   localparam logic [CFG_W-1:0] RESET_GAP_INIT = 16'd60;
   localparam logic [CFG_W-1:0] MIN_READ_INIT  = 16'd5;
   localparam logic [CFG_W-1:0] COOLDOWN_INIT  = 16'd30;
   localparam logic [CFG_W-1:0] COLD_LIM_INIT  = 16'd160;
   localparam logic [CFG_W-1:0] HOT_LIM_INIT   = 16'd480;

   typedef enum logic [2:0] {
      STATUS_INVALID = 3'd0,
      STATUS_ACCUM   = 3'd1,
      STATUS_AVG_OK  = 3'd2,
      STATUS_COLD    = 3'd3,
      STATUS_HOT     = 3'd4
   } status_type;

endpackage

// File: hdl/sravg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor running average alert channels
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface sravg_req_if;
   import sravg_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [ID_W-1:0]          sensor_number;
   logic signed [TEMP_W-1:0] temperature;
   logic [TIME_W-1:0]        reading_time;
   logic [TIME_W-1:0]        current_time;

   modport source (output valid, sensor_number, temperature, reading_time, current_time,
                   input ready);
   modport sink (input valid, sensor_number, temperature, reading_time, current_time,
                 output ready);
endinterface

interface sravg_rsp_if;
   import sravg_pkg::*;

   logic                      valid;
   logic                      ready;
   status_type                status;
   logic signed [TEMP_W-1:0]  average;
   logic [COUNT_W-1:0]        reading_count;
   logic                      window_restarted;

   modport source (output valid, status, average, reading_count, window_restarted,
                   input ready);
   modport sink (input valid, status, average, reading_count, window_restarted,
                 output ready);
endinterface

interface sravg_csr_if;
   import sravg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CFG_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/sensor_running_average_alert_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor running average alert core
// Per-sensor running average of temperature readings with cold/hot alerts.
// ----------------------------------------------------------------------------
// Each request carries one reading and yields exactly one response. A valid
// sensor request runs from acceptance through these steps: read and update
// the sensor's table entry, 32 iterations of the shared restoring divider
// (one quotient bit per cycle), the alert compare, the hand-off to the
// response register and a return to idle, where the next request is taken.
// A reading that leaves the window below the minimum count skips the divider
// and the alert compare, and an invalid sensor number goes straight from idle
// to the hand-off. The hand-off waits while an earlier response is still
// pending unaccepted. The request side is ready only while the sequencer is
// idle; a finished response waits in its own output register, so a new
// request can be taken while the previous response is still pending.
// Register writes are always accepted and are expected only while no request
// is in flight.
module sensor_running_average_alert_core (
   input  logic clock,
   input  logic reset,
   sravg_req_if.sink   req_chan,
   sravg_rsp_if.source rsp_chan,
   sravg_csr_if.sink   csr_chan
);
   import sravg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_ALERT,
      ST_FINISH
   } state_type;

   localparam int DIV_STEPS = SUM_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Configuration registers.
   logic [CFG_W-1:0]        gap_cfg_ff;
   logic [CFG_W-1:0]        min_cfg_ff;
   logic [CFG_W-1:0]        cool_cfg_ff;
   logic signed [CFG_W-1:0] cold_cfg_ff;
   logic signed [CFG_W-1:0] hot_cfg_ff;

   // Per-sensor tables.
   logic [SUM_W-1:0]   sum_mem_ff  [NUM_SENSORS];
   logic [COUNT_W-1:0] cnt_mem_ff  [NUM_SENSORS];
   logic [TIME_W-1:0]  upd_mem_ff  [NUM_SENSORS];
   logic [TIME_W-1:0]  alrt_mem_ff [NUM_SENSORS];

   // Sequencer and datapath registers.
   state_type                state_ff, state_in;
   logic [ID_W-1:0]          id_ff, id_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic [TIME_W-1:0]        rtime_ff, rtime_in;
   logic [TIME_W-1:0]        now_ff, now_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [COUNT_W-1:0]       rem_ff, rem_in;
   logic [COUNT_W-1:0]       div_ff, div_in;
   logic                     neg_ff, neg_in;
   logic                     restart_ff, restart_in;
   logic                     alert_ok_ff, alert_ok_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   status_type               status_ff, status_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;

   // Response register.
   logic                     rsp_valid_ff, rsp_valid_in;
   status_type               rsp_status_ff, rsp_status_in;
   logic signed [TEMP_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic [COUNT_W-1:0]       rsp_cnt_ff, rsp_cnt_in;
   logic                     rsp_restart_ff, rsp_restart_in;

   // Table write controls.
   logic                  tbl_wr;
   logic                  alrt_wr;
   logic [SUM_W-1:0]      new_sum;
   logic [COUNT_W-1:0]    new_cnt;

   logic                  req_take;
   logic                  id_ok;
   logic [SENSOR_W-1:0]   idx;
   logic [SUM_W-1:0]      old_sum;
   logic [COUNT_W-1:0]    old_cnt;
   logic [TIME_W:0]       gap_diff;
   logic [TIME_W:0]       cool_diff;
   logic                  restart;
   logic                  cool_ok;
   logic [SUM_W-1:0]      temp_ext;
   logic [COUNT_W+1:0]    trial;
   logic [SUM_W-1:0]      quo_signed;
   logic signed [TEMP_W-1:0] avg_now;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_take       = req_chan.valid && req_chan.ready;
   assign id_ok          = (req_chan.sensor_number != '0) &&
                           ({1'b0, req_chan.sensor_number} < (ID_W + 1)'(NUM_SENSORS));

   assign idx      = id_ff[SENSOR_W-1:0];
   assign old_sum  = sum_mem_ff[idx];
   assign old_cnt  = cnt_mem_ff[idx];
   assign temp_ext = {{(SUM_W - TEMP_W){temp_ff[TEMP_W-1]}}, temp_ff};

   // Time differences are 33-bit signed so a stored time in the future
   // reads as a negative gap: no restart, no alert.
   assign gap_diff  = {1'b0, now_ff} - {1'b0, upd_mem_ff[idx]};
   assign cool_diff = {1'b0, now_ff} - {1'b0, alrt_mem_ff[idx]};
   assign restart   = $signed(gap_diff) > $signed({{(TIME_W + 1 - CFG_W){1'b0}}, gap_cfg_ff});
   assign cool_ok   = $signed(cool_diff) >= $signed({{(TIME_W + 1 - CFG_W){1'b0}}, cool_cfg_ff});

   // Window update: restart, accumulate, or freeze once the count saturates.
   always_comb begin
      if (restart) begin
         new_sum = temp_ext;
         new_cnt = COUNT_W'(1);
      end else if (old_cnt != '1) begin
         new_sum = old_sum + temp_ext;
         new_cnt = old_cnt + COUNT_W'(1);
      end else begin
         new_sum = old_sum;
         new_cnt = old_cnt;
      end
   end

   // One restoring division step: shift in the next dividend bit and try to
   // subtract the count.
   assign trial = {1'b0, rem_ff, quo_ff[SUM_W-1]} - {2'b00, div_ff};

   assign quo_signed = neg_ff ? (SUM_W'(0) - quo_ff) : quo_ff;
   // The mean of 16-bit readings always fits back into 16 bits.
   assign avg_now    = quo_signed[TEMP_W-1:0];

   assign tbl_wr  = (state_ff == ST_CALC);
   assign alrt_wr = (state_ff == ST_ALERT) && alert_ok_ff &&
                    ((avg_now < cold_cfg_ff) || (avg_now > hot_cfg_ff));

   always_comb begin
      state_in       = state_ff;
      id_in          = id_ff;
      temp_in        = temp_ff;
      rtime_in       = rtime_ff;
      now_in         = now_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      div_in         = div_ff;
      neg_in         = neg_ff;
      restart_in     = restart_ff;
      alert_ok_in    = alert_ok_ff;
      step_in        = step_ff;
      status_in      = status_ff;
      avg_in         = avg_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_cnt_in     = rsp_cnt_ff;
      rsp_restart_in = rsp_restart_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               id_in    = req_chan.sensor_number;
               temp_in  = req_chan.temperature;
               rtime_in = req_chan.reading_time;
               now_in   = req_chan.current_time;
               if (id_ok) begin
                  state_in = ST_CALC;
               end else begin
                  status_in  = STATUS_INVALID;
                  avg_in     = '0;
                  div_in     = '0;
                  restart_in = 1'b0;
                  state_in   = ST_FINISH;
               end
            end
         end
         ST_CALC: begin
            restart_in  = restart;
            alert_ok_in = cool_ok;
            div_in      = new_cnt;
            neg_in      = new_sum[SUM_W-1];
            quo_in      = new_sum[SUM_W-1] ? (SUM_W'(0) - new_sum) : new_sum;
            rem_in      = '0;
            step_in     = STEP_W'(DIV_STEPS - 1);
            // A minimum of zero acts as one, which the count always meets.
            if (new_cnt >= min_cfg_ff) begin
               state_in = ST_DIV;
            end else begin
               status_in = STATUS_ACCUM;
               avg_in    = '0;
               state_in  = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (!trial[COUNT_W+1]) begin
               rem_in = trial[COUNT_W-1:0];
            end else begin
               rem_in = {rem_ff[COUNT_W-2:0], quo_ff[SUM_W-1]};
            end
            quo_in  = {quo_ff[SUM_W-2:0], !trial[COUNT_W+1]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_ALERT;
            end
         end
         ST_ALERT: begin
            avg_in    = avg_now;
            status_in = STATUS_AVG_OK;
            // Cold wins when both limits are crossed.
            if (alert_ok_ff) begin
               priority if (avg_now < cold_cfg_ff) begin
                  status_in = STATUS_COLD;
               end else if (avg_now > hot_cfg_ff) begin
                  status_in = STATUS_HOT;
               end
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_status_in  = status_ff;
               rsp_avg_in     = avg_ff;
               rsp_cnt_in     = div_ff;
               rsp_restart_in = restart_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      id_ff          <= id_in;
      temp_ff        <= temp_in;
      rtime_ff       <= rtime_in;
      now_ff         <= now_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      div_ff         <= div_in;
      neg_ff         <= neg_in;
      restart_ff     <= restart_in;
      alert_ok_ff    <= alert_ok_in;
      step_ff        <= step_in;
      status_ff      <= status_in;
      avg_ff         <= avg_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_cnt_ff     <= rsp_cnt_in;
      rsp_restart_ff <= rsp_restart_in;
   end

   // Sensor tables start out all zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SENSORS; i++) begin
            sum_mem_ff[i]  <= '0;
            cnt_mem_ff[i]  <= '0;
            upd_mem_ff[i]  <= '0;
            alrt_mem_ff[i] <= '0;
         end
      end else begin
         if (tbl_wr) begin
            sum_mem_ff[idx] <= new_sum;
            cnt_mem_ff[idx] <= new_cnt;
            upd_mem_ff[idx] <= rtime_ff;
         end
         if (alrt_wr) begin
            alrt_mem_ff[idx] <= now_ff;
         end
      end
   end

   // Register writes; indexes beyond the list are dropped.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_cfg_ff  <= RESET_GAP_INIT;
         min_cfg_ff  <= MIN_READ_INIT;
         cool_cfg_ff <= COOLDOWN_INIT;
         cold_cfg_ff <= COLD_LIM_INIT;
         hot_cfg_ff  <= HOT_LIM_INIT;
      end else if (csr_chan.valid && csr_chan.ready) begin
         unique case (csr_chan.index)
            CSR_RESET_GAP: gap_cfg_ff  <= csr_chan.data;
            CSR_MIN_READ:  min_cfg_ff  <= csr_chan.data;
            CSR_COOLDOWN:  cool_cfg_ff <= csr_chan.data;
            CSR_COLD_LIM:  cold_cfg_ff <= csr_chan.data;
            CSR_HOT_LIM:   hot_cfg_ff  <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.status           = rsp_status_ff;
   assign rsp_chan.average          = rsp_avg_ff;
   assign rsp_chan.reading_count    = rsp_cnt_ff;
   assign rsp_chan.window_restarted = rsp_restart_ff;

`ifndef SYNTHESIS
   // A new response only appears out of the hand-off state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the hand-off state");

   // The divider never runs with a zero count.
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (div_ff != '0))
      else $error("divider running with a zero count");

   // Without an average the reported average is zero.
   a_avg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_INVALID || rsp_status_ff == STATUS_ACCUM)
      |-> (rsp_avg_ff == '0))
      else $error("average reported without enough readings");

   // An invalid sensor reports no count and no restart.
   a_invalid_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_INVALID)
      |-> (rsp_cnt_ff == '0) && !rsp_restart_ff)
      else $error("invalid sensor response carries window data");

   // An accepted request keeps the sequencer busy in the next cycle.
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> !req_chan.ready)
      else $error("request side ready right after a request");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor running average alert testbench
// Drives temperature reading requests into the core and predicts each response
// with a cycle-free model of the per-sensor sum, count and alert tables. Every
// response is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module tb;
   import sravg_pkg::*;

   // A spare register index that the core must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 3'd7;

   // Each request is one reading plus the number of idle cycles that the
   // sender spends before presenting it.
   typedef struct {
      logic [ID_W-1:0]          sensor;
      logic signed [TEMP_W-1:0] temp;
      logic [TIME_W-1:0]        rtime;
      logic [TIME_W-1:0]        now;
      int                       idle;
   } reading_type;

   typedef struct {
      status_type               status;
      logic signed [TEMP_W-1:0] average;
      logic [COUNT_W-1:0]       count;
      logic                     restarted;
   } alert_result_type;

   // The response side cycles through three behaviors: always ready, a fixed
   // rotating stall pattern, and sparse random readiness.
   typedef enum logic [1:0] {
      RX_OPEN,
      RX_PATTERN,
      RX_SPARSE
   } receive_mode_type;

   logic clock;
   logic reset;

   sravg_req_if req_if();
   sravg_rsp_if rsp_if();
   sravg_csr_if csr_if();

   sensor_running_average_alert_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always #2 clock = ~clock;

   // Predicted register contents, mirrored on every register write.
   logic [CFG_W-1:0]        gap_limit;
   logic [CFG_W-1:0]        min_count;
   logic [CFG_W-1:0]        cooldown_len;
   logic signed [CFG_W-1:0] cold_threshold;
   logic signed [CFG_W-1:0] hot_threshold;

   // Predicted per-sensor tables.
   logic [SUM_W-1:0]   window_sum       [NUM_SENSORS];
   logic [COUNT_W-1:0] window_count     [NUM_SENSORS];
   logic [TIME_W-1:0]  last_update_time [NUM_SENSORS];
   logic [TIME_W-1:0]  alert_stamp      [NUM_SENSORS];

   reading_type      readings_to_send [$];
   alert_result_type expected_results [$];

   int            queued_total;
   int            accepted_total;
   int            mismatch_count;
   int            idle_spent;
   int            burst_left;
   logic          req_taken;
   logic [TIME_W-1:0] wall_clock;

   receive_mode_type ready_mode;
   int            mode_cycles;
   logic [12:0]   stall_pattern;

   // Works out the response for one accepted reading and advances the
   // predicted tables exactly as the core is meant to.
   function automatic alert_result_type predict_reading(input reading_type rd);
      alert_result_type res;
      int            idx;
      longint        since_update;
      longint        since_alert;
      longint        run_sum;
      longint        run_avg;
      res.status    = STATUS_INVALID;
      res.average   = '0;
      res.count     = '0;
      res.restarted = 1'b0;
      // Sensor zero and numbers past the table leave every table untouched.
      if (rd.sensor == 0 || rd.sensor >= NUM_SENSORS) begin
         return res;
      end
      idx = int'(rd.sensor);
      // Time differences are taken without wrap, so a current time that lies
      // before the stored time gives a negative difference.
      since_update = longint'({32'h0, rd.now}) - longint'({32'h0, last_update_time[idx]});
      if (since_update > longint'({48'h0, gap_limit})) begin
         window_sum[idx]   = {{(SUM_W-TEMP_W){rd.temp[TEMP_W-1]}}, rd.temp};
         window_count[idx] = 16'd1;
         res.restarted     = 1'b1;
      end else if (window_count[idx] != 16'hFFFF) begin
         window_sum[idx]   = window_sum[idx] + {{(SUM_W-TEMP_W){rd.temp[TEMP_W-1]}}, rd.temp};
         window_count[idx] = window_count[idx] + 16'd1;
      end
      // A saturated count freezes the sum, but the update time still moves.
      last_update_time[idx] = rd.rtime;
      res.count = window_count[idx];
      if (window_count[idx] >= min_count && window_count[idx] != 0) begin
         run_sum = longint'($signed(window_sum[idx]));
         run_avg = run_sum / longint'({48'h0, window_count[idx]});
         res.status  = STATUS_AVG_OK;
         res.average = run_avg[TEMP_W-1:0];
         since_alert = longint'({32'h0, rd.now}) - longint'({32'h0, alert_stamp[idx]});
         // The limits are compared with the full quotient; cold wins when
         // both limits are crossed.
         if (since_alert >= longint'({48'h0, cooldown_len})) begin
            if (run_avg < longint'(cold_threshold)) begin
               res.status       = STATUS_COLD;
               alert_stamp[idx] = rd.now;
            end else if (run_avg > longint'(hot_threshold)) begin
               res.status       = STATUS_HOT;
               alert_stamp[idx] = rd.now;
            end
         end
      end else begin
         res.status = STATUS_ACCUM;
      end
      return res;
   endfunction

   task automatic log_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at %0t: %s", $realtime, msg);
      end
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         log_mismatch($sformatf("%s expected %0h, got %0h", field, want, got));
      end
   endtask

   // Sender bursts: a run of back-to-back requests, then one random gap. The
   // gaps reach past the longest divide so they land on every phase of it.
   function automatic int next_idle();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? int'($urandom_range(20, 60))
                                               : int'($urandom_range(0, 10));
      return int'($urandom_range(1, 40));
   endfunction

   function automatic void queue_reading(input logic [ID_W-1:0] sensor, input int temp,
                                         input logic [TIME_W-1:0] rtime,
                                         input logic [TIME_W-1:0] now, input int idle);
      reading_type rd;
      rd.sensor = sensor;
      rd.temp   = temp[TEMP_W-1:0];
      rd.rtime  = rtime;
      rd.now    = now;
      rd.idle   = idle;
      readings_to_send.push_back(rd);
      queued_total++;
   endfunction

   // Mostly a steady stream of readings on a few sensors with small time
   // steps, mixed with idle gaps past the restart limit, readings from the
   // past, random wall times and out-of-range sensor numbers.
   task automatic queue_random_reading();
      logic [ID_W-1:0]   sensor;
      logic [TIME_W-1:0] now;
      logic [TIME_W-1:0] rtime;
      int                temp;
      int                pick;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
         sensor = ID_W'($urandom);
      end else if (pick < 50) begin
         sensor = ID_W'($urandom_range(1, 4));
      end else begin
         sensor = ID_W'($urandom_range(1, NUM_SENSORS - 1));
      end
      temp = ($urandom_range(0, 9) == 0) ? int'($urandom)
                                         : int'($urandom_range(0, 2400)) - 800;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         wall_clock = wall_clock + $urandom_range(0, 6);
      end else if (pick < 80) begin
         wall_clock = wall_clock + {16'h0, gap_limit} + $urandom_range(1, 100);
      end else if (pick < 94) begin
         wall_clock = wall_clock + $urandom_range(20, 120);
      end else begin
         wall_clock = $urandom;
      end
      now = wall_clock;
      if ($urandom_range(0, 9) == 0) begin
         now = wall_clock - $urandom_range(1, 500);
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
         rtime = now;
      end else if (pick < 95) begin
         rtime = now - $urandom_range(0, 50);
      end else begin
         rtime = $urandom;
      end
      queue_reading(sensor, temp, rtime, now, next_idle());
   endtask

   // Register writes happen only with the core idle; the predicted copy is
   // updated at the accepting edge.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      case (idx)
         CSR_RESET_GAP: gap_limit      = value;
         CSR_MIN_READ:  min_count      = value;
         CSR_COOLDOWN:  cooldown_len   = value;
         CSR_COLD_LIM:  cold_threshold = value;
         CSR_HOT_LIM:   hot_threshold  = value;
         default: ;
      endcase
      @(negedge clock);
      csr_if.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic randomize_registers();
      int cold;
      cold = int'($urandom_range(0, 600)) - 200;
      write_register(CSR_RESET_GAP, ($urandom_range(0, 9) == 0) ? CFG_W'($urandom)
                                                              : CFG_W'($urandom_range(0, 120)));
      write_register(CSR_MIN_READ, CFG_W'($urandom_range(1, 6)));
      write_register(CSR_COOLDOWN, ($urandom_range(0, 9) == 0) ? CFG_W'($urandom)
                                                             : CFG_W'($urandom_range(0, 60)));
      write_register(CSR_COLD_LIM, CFG_W'(cold));
      write_register(CSR_HOT_LIM, CFG_W'(cold + int'($urandom_range(0, 800)) - 100));
   endtask

   // Holds the sender until every queued request has been accepted and
   // answered, which leaves the core idle.
   task automatic drain_all();
      while (accepted_total != queued_total || expected_results.size() != 0) begin
         @(negedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   // Request driver. A new request goes out only once the previous one was
   // taken, and only after the idle cycles that belong to it have passed.
   always @(negedge clock) begin : driver
      reading_type rd;
      if (reset) begin
         req_if.valid <= 1'b0;
         idle_spent = 0;
      end else if (!req_if.valid || req_taken) begin
         if (readings_to_send.size() != 0 && idle_spent < readings_to_send[0].idle) begin
            req_if.valid <= 1'b0;
            idle_spent++;
         end else if (readings_to_send.size() != 0) begin
            rd = readings_to_send.pop_front();
            req_if.valid         <= 1'b1;
            req_if.sensor_number <= rd.sensor;
            req_if.temperature   <= rd.temp;
            req_if.reading_time  <= rd.rtime;
            req_if.current_time  <= rd.now;
            idle_spent = 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Response readiness, switching behavior at random intervals.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_if.ready  <= 1'b0;
         ready_mode    <= RX_OPEN;
         mode_cycles   <= 0;
         stall_pattern <= 13'h1A5B;
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[12:1]};
         if (mode_cycles == 0) begin
            ready_mode  <= receive_mode_type'($urandom_range(0, 2));
            mode_cycles <= $urandom_range(50, 400);
         end else begin
            mode_cycles <= mode_cycles - 1;
         end
         case (ready_mode)
            RX_OPEN:    rsp_if.ready <= 1'b1;
            RX_PATTERN: rsp_if.ready <= stall_pattern[0];
            default:    rsp_if.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Monitor. Responses are checked before the request of the same edge is
   // predicted, so a stray response can never consume a fresh prediction.
   always @(posedge clock) begin : monitor
      alert_result_type want;
      reading_type      seen;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_results.size() == 0) begin
               log_mismatch("response arrived with no request outstanding");
            end else begin
               want = expected_results.pop_front();
               compare_field("status", 32'(want.status), 32'(rsp_if.status));
               compare_field("average", 32'(want.average), 32'(rsp_if.average));
               compare_field("reading_count", 32'(want.count), 32'(rsp_if.reading_count));
               compare_field("window_restarted", 32'(want.restarted),
                             32'(rsp_if.window_restarted));
            end
         end
         if (req_if.valid && req_if.ready) begin
            seen.sensor = req_if.sensor_number;
            seen.temp   = req_if.temperature;
            seen.rtime  = req_if.reading_time;
            seen.now    = req_if.current_time;
            seen.idle   = 0;
            expected_results.push_back(predict_reading(seen));
            accepted_total++;
         end
      end
   end

   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.sensor_number = '0;
      req_if.temperature   = '0;
      req_if.reading_time  = '0;
      req_if.current_time  = '0;
      rsp_if.ready         = 1'b0;
      csr_if.valid         = 1'b0;
      csr_if.index         = CSR_RESET_GAP;
      csr_if.data          = '0;
      gap_limit            = RESET_GAP_INIT;
      min_count            = MIN_READ_INIT;
      cooldown_len         = COOLDOWN_INIT;
      cold_threshold       = COLD_LIM_INIT;
      hot_threshold        = HOT_LIM_INIT;
      for (int i = 0; i < NUM_SENSORS; i++) begin
         window_sum[i]       = '0;
         window_count[i]     = '0;
         last_update_time[i] = '0;
         alert_stamp[i]      = '0;
      end
      queued_total   = 0;
      accepted_total = 0;
      mismatch_count = 0;
      burst_left     = 0;
      wall_clock     = 32'd5000;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed readings under the reset settings: gap 60, five readings
      // needed, cooldown 30, cold below 160, hot above 480.
      // Invalid sensor numbers, with the fields at their extremes.
      queue_reading(8'd0, 0, 32'd0, 32'd0, next_idle());
      queue_reading(8'(NUM_SENSORS), 320, 32'd10, 32'd10, next_idle());
      queue_reading(8'hFF, -32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, next_idle());
      // Sensor 1 restarts on its first reading, then reaches the minimum
      // count with a cold average and alerts.
      for (int t = 100; t <= 104; t++) begin
         queue_reading(8'd1, 100, 32'(t), 32'(t), next_idle());
      end
      // Still cold, but inside the cooldown, so only the average comes back.
      queue_reading(8'd1, 100, 32'd110, 32'd110, next_idle());
      queue_reading(8'd1, -32768, 32'd111, 32'd111, next_idle());
      // Sensor 2 runs hot at the largest temperature.
      for (int t = 200; t <= 204; t++) begin
         queue_reading(8'd2, 32767, 32'(t), 32'(t), next_idle());
      end
      // A current time before the last update: no restart and no alert.
      queue_reading(8'd2, 0, 32'd150, 32'd150, next_idle());
      // Idle longer than the gap: the window restarts below the minimum.
      queue_reading(8'd2, 500, 32'd212, 32'd212, next_idle());
      // A top sensor accumulating the most negative temperature.
      for (int t = 300; t <= 302; t++) begin
         queue_reading(8'(NUM_SENSORS - 1), -32768, 32'(t), 32'(t), next_idle());
      end
      drain_all();

      // Register extremes: any later time restarts, a minimum of zero acts as
      // one, no cooldown, and the limits cross so that cold must win.
      write_register(CSR_RESET_GAP, 16'h0000);
      write_register(CSR_MIN_READ, 16'h0000);
      write_register(CSR_COOLDOWN, 16'h0000);
      write_register(CSR_COLD_LIM, 16'h7FFF);
      write_register(CSR_HOT_LIM, 16'h8000);
      write_register(CSR_SPARE, 16'hFFFF);
      queue_reading(8'd3, 1000, 32'd1000, 32'd1000, next_idle());
      queue_reading(8'd3, 1000, 32'd1000, 32'd1000, next_idle());
      queue_reading(8'd3, -1000, 32'd999, 32'd999, next_idle());
      queue_reading(8'd3, 32767, 32'hFFFF_FFFF, 32'd5, next_idle());
      queue_reading(8'd3, -32768, 32'd7, 32'hFFFF_FFFF, next_idle());
      repeat (60) queue_random_reading();
      drain_all();

      // Random settings with random readings, each phase drained before the
      // registers change.
      wall_clock = 32'd5000;
      repeat (4) begin
         randomize_registers();
         repeat (110) queue_random_reading();
         drain_all();
      end
      // One more batch of random readings with the settings left as they are.
      repeat (40) queue_random_reading();
      drain_all();

      // Allow a full divide worth of cycles for any stray response.
      repeat (60) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
